@@ rtl/lpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcr_pkg
// Shared constants, register indexes and types of the peak clip raster unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcr_pkg;

   // defaults of the top level parameters
   localparam int MAX_COLS_DEF   = 1024;
   localparam int PIXEL_BITS_DEF = 16;

   // fixed port field widths
   localparam int PIXEL_W    = 16;
   localparam int ROW_W      = 16;
   localparam int OUT_COL_W  = 10;
   localparam int VALUE_W    = 16;
   localparam int CFG_COLS_W = 11;
   localparam int CFG_ROWS_W = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // result queue: depth must be a power of two
   localparam int RSP_DEPTH = 8;
   // results one request can release
   localparam int MAX_RSP   = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 4'd1;

   // neighbor presence flags for the three finishes of one request
   typedef struct packed {
      logic has_a;     // pixel above is finished by this request
      logic up_a;      // it has an upper neighbor
      logic left_a;    // it has a left neighbor
      logic right_a;   // it has a right neighbor
      logic has_b;     // last row: pixel to the left is finished
      logic up_bc;     // last row pixels have an upper neighbor
      logic left_b;    // left pixel has its own left neighbor
      logic has_c;     // last pixel of the frame is finished
      logic left_c;    // last pixel has a left neighbor
   } peak_ctl_type;

   // one result item
   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic [VALUE_W-1:0]   value;
      logic                 run_last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/lpcr_ram.sv @@
// ----------------------------------------------------------------------------
// lpcr_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/lpcr_peak.sv @@
// ----------------------------------------------------------------------------
// lpcr_peak
// Peak test for the up to three pixels finished by one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcr_peak #(
   parameter int PW = lpcr_pkg::PIXEL_BITS_DEF
) (
   input  wire lpcr_pkg::peak_ctl_type ctl,
   input  wire logic [PW-1:0]          px,        // new original pixel
   input  wire logic [PW-1:0]          a_self,    // original above
   input  wire logic [PW-1:0]          a_up,      // final two rows up
   input  wire logic [PW-1:0]          a_left,    // final up-left
   input  wire logic [PW-1:0]          a_right,   // original up-right
   input  wire logic [PW-1:0]          b_self,    // original to the left
   input  wire logic [PW-1:0]          b_up,      // final up-left
   input  wire logic [PW-1:0]          b_left,    // final two to the left
   output logic      [PW-1:0]          va,
   output logic      [PW-1:0]          vb,
   output logic      [PW-1:0]          vc
);

   // strict peak over the present neighbors is clipped to their maximum
   function automatic logic [PW-1:0] finish(
      input logic [PW-1:0] own,
      input logic          hu,
      input logic [PW-1:0] up_v,
      input logic          hl,
      input logic [PW-1:0] left_v,
      input logic          hd,
      input logic [PW-1:0] down_v,
      input logic          hr,
      input logic [PW-1:0] right_v
   );
      logic          peak;
      logic [PW-1:0] mx;
      peak = 1'b1;
      mx   = '0;
      if (hu) begin
         if (own <= up_v) peak = 1'b0;
         else if (up_v > mx) mx = up_v;
      end
      if (hl) begin
         if (own <= left_v) peak = 1'b0;
         else if (left_v > mx) mx = left_v;
      end
      if (hd) begin
         if (own <= down_v) peak = 1'b0;
         else if (down_v > mx) mx = down_v;
      end
      if (hr) begin
         if (own <= right_v) peak = 1'b0;
         else if (right_v > mx) mx = right_v;
      end
      return peak ? mx : own;
   endfunction

   // pixel above: lower neighbor just arrived
   assign va = finish(a_self, ctl.up_a, a_up, ctl.left_a, a_left,
                      1'b1, px, ctl.right_a, a_right);

   // last row, pixel to the left: right neighbor just arrived
   assign vb = finish(b_self, ctl.up_bc, b_up, ctl.left_b, b_left,
                      1'b0, '0, 1'b1, px);

   // last pixel of the frame, sees the values finished above and left of it
   assign vc = finish(px, ctl.up_bc, va, ctl.left_c, vb,
                      1'b0, '0, 1'b0, '0);

endmodule

`default_nettype wire

@@ rtl/lpcr_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// lpcr_rsp_fifo
// Result queue taking up to three results per cycle, releasing one per cycle on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcr_rsp_fifo #(
   parameter int DEPTH = lpcr_pkg::RSP_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lpcr_pkg::MAX_RSP-1:0]  push_mask,
   input  wire lpcr_pkg::rsp_item_type        push_item [lpcr_pkg::MAX_RSP],
   input  wire logic                          pop,
   output lpcr_pkg::rsp_item_type             head,
   output logic      [$clog2(DEPTH+1)-1:0]    level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam int NR    = lpcr_pkg::MAX_RSP;

   lpcr_pkg::rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] slot_ptr [NR];

   // pack the present results into consecutive slots
   always_comb begin
      logic [PTR_W-1:0] acc;
      logic [LVL_W-1:0] cnt;
      acc = wr_ptr_ff;
      cnt = '0;
      for (int i = 0; i < NR; i++) begin
         slot_ptr[i] = acc;
         acc = acc + PTR_W'(push_mask[i]);
         cnt = cnt + LVL_W'(push_mask[i]);
      end
      wr_ptr_in = acc;
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      level_in  = level_ff + cnt - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NR; i++) begin
         if (push_mask[i]) begin
            mem_ff[slot_ptr[i]] <= push_item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule

`default_nettype wire

@@ rtl/local_peak_clip_raster_unit.sv @@
// A result passes through stage 1 and the result queue before it appears on rsp.
// Throughput: one pixel per cycle; one packed line RAM read and one write per pixel.
// Last row requests release up to three results; the single result port then
// limits the input to one pixel per released result once results back up in the queue.
// Reset: position cleared, frame set to 1x1, result queue emptied; the line RAM
// is not cleared (no clearing pass), every entry is written before it is read.
// ----------------------------------------------------------------------------
// local_peak_clip_raster_unit
// Streaming peak clipping over a raster frame using a packed line memory.
// ----------------------------------------------------------------------------
`default_nettype none

module local_peak_clip_raster_unit #(
   parameter int MAX_COLS   = lpcr_pkg::MAX_COLS_DEF,
   parameter int PIXEL_BITS = lpcr_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel requests
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lpcr_pkg::PIXEL_W-1:0]       req_pixel,
   // results
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [lpcr_pkg::ROW_W-1:0]         rsp_out_row,
   output logic      [lpcr_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic      [lpcr_pkg::VALUE_W-1:0]       rsp_value,
   output logic                                    rsp_run_last,
   // configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lpcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lpcr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ECW   = COL_W + 1;
   localparam int PW    = PIXEL_BITS;
   localparam int WW    = 2 * PW;
   localparam int ROW_W = lpcr_pkg::ROW_W;
   localparam int OCW   = lpcr_pkg::OUT_COL_W;
   localparam int VW    = lpcr_pkg::VALUE_W;
   localparam int CCW   = lpcr_pkg::CFG_COLS_W;
   localparam int CMPW  = (CCW > ECW) ? CCW : ECW;
   localparam int DEPTH = lpcr_pkg::RSP_DEPTH;
   localparam int NR    = lpcr_pkg::MAX_RSP;
   localparam int LVL_W = $clog2(DEPTH + 1);

   // frame geometry and input position
   logic [ECW-1:0]   eff_cols_ff, eff_cols_in;
   logic [ROW_W-1:0] eff_rows_ff, eff_rows_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;

   // stage 1: accepted request waiting for its line RAM word
   logic                   s1_vld_ff;
   logic [PW-1:0]          s1_px_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   logic [COL_W-1:0]       s1_col_ff;
   logic                   s1_wrap_ff;
   lpcr_pkg::peak_ctl_type s1_ctl_ff;
   logic                   fwd_hit_ff;
   logic [WW-1:0]          fwd_data_ff;

   // running neighbor state
   logic [WW-1:0] cur_ff;        // {final, original} of the current column
   logic [PW-1:0] last_va_ff;    // final up-left
   logic [PW-1:0] tail_left_ff;  // last row final to the left
   logic [PW-1:0] prev_px_ff;    // original to the left

   logic                   req_accept;
   logic                   csr_write;
   logic [ROW_W-1:0]       row_cur;
   logic [COL_W-1:0]       col_cur;
   logic                   last_row;
   logic                   col_last;
   logic [COL_W-1:0]       col_nxt;
   logic [ROW_W-1:0]       row_nxt;
   lpcr_pkg::peak_ctl_type ctl_new;
   logic [PW-1:0]          px_new;

   logic [WW-1:0]  ram_rdata;
   logic [WW-1:0]  rd_word;
   logic [WW-1:0]  wr_word;
   logic [PW-1:0]  va, vb, vc;

   lpcr_pkg::rsp_item_type push_item [NR];
   logic [NR-1:0]          push_mask;
   lpcr_pkg::rsp_item_type head;
   logic [LVL_W-1:0]       rsp_level;
   logic [LVL_W:0]         room_need;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign room_need  = (LVL_W+1)'(rsp_level) + (s1_vld_ff ? (LVL_W+1)'(NR) : '0);
   assign req_stall  = room_need > (LVL_W+1)'(DEPTH - NR);
   assign req_accept = req_valid && !req_stall;
   assign px_new     = PW'(req_pixel);

   // ---------------------------------------------------------------------
   // Position of the incoming pixel and its neighbor flags
   // ---------------------------------------------------------------------
   always_comb begin
      row_cur  = (in_row_ff >= eff_rows_ff) ? '0 : in_row_ff;
      col_cur  = (ECW'(in_col_ff) >= eff_cols_ff) ? '0 : in_col_ff;
      last_row = ((ROW_W+1)'(row_cur) + (ROW_W+1)'(1)) == (ROW_W+1)'(eff_rows_ff);
      col_last = (ECW'(col_cur) + ECW'(1)) == eff_cols_ff;
      col_nxt  = col_last ? '0 : col_cur + COL_W'(1);
      row_nxt  = col_last ? (last_row ? '0 : row_cur + ROW_W'(1)) : row_cur;

      ctl_new.has_a   = row_cur != '0;
      ctl_new.up_a    = row_cur > ROW_W'(1);
      ctl_new.left_a  = col_cur != '0;
      ctl_new.right_a = !col_last;
      ctl_new.has_b   = last_row && (col_cur != '0);
      ctl_new.up_bc   = row_cur != '0;
      ctl_new.left_b  = col_cur > COL_W'(1);
      ctl_new.has_c   = last_row && col_last;
      ctl_new.left_c  = col_cur != '0;
   end

   // ---------------------------------------------------------------------
   // Configuration decode and position update
   // ---------------------------------------------------------------------
   always_comb begin
      logic [CMPW-1:0] cols_wide;
      cols_wide   = CMPW'(csr_wdata[CCW-1:0]);
      eff_cols_in = eff_cols_ff;
      eff_rows_in = eff_rows_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      if (req_accept) begin
         in_row_in = row_nxt;
         in_col_in = col_nxt;
      end
      if (csr_write) begin
         unique case (csr_index)
            lpcr_pkg::CSR_FRAME_COLS: begin
               if (cols_wide == '0) eff_cols_in = ECW'(1);
               else if (cols_wide > CMPW'(MAX_COLS)) eff_cols_in = ECW'(MAX_COLS);
               else eff_cols_in = ECW'(cols_wide);
               in_row_in = '0;
               in_col_in = '0;
            end
            lpcr_pkg::CSR_FRAME_ROWS: begin
               eff_rows_in = (csr_wdata == '0) ? ROW_W'(1) : ROW_W'(csr_wdata);
               in_row_in   = '0;
               in_col_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_cols_ff <= ECW'(1);
         eff_rows_ff <= ROW_W'(1);
         in_row_ff   <= '0;
         in_col_ff   <= '0;
      end else begin
         eff_cols_ff <= eff_cols_in;
         eff_rows_ff <= eff_rows_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line RAM: word {final of row above, pending original} per column.
   // Read at the next column on accept, written by stage 1.
   // ---------------------------------------------------------------------
   lpcr_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_vld_ff),
      .waddr (s1_col_ff),
      .wdata (wr_word),
      .re    (req_accept),
      .raddr (col_nxt),
      .rdata (ram_rdata)
   );

   // forward the word written in the same cycle as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= req_accept;
         fwd_hit_ff <= req_accept && s1_vld_ff && (s1_col_ff == col_nxt);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_word;
      if (req_accept) begin
         s1_px_ff   <= px_new;
         s1_row_ff  <= row_cur;
         s1_col_ff  <= col_cur;
         s1_wrap_ff <= col_last && (col_cur == '0);
         s1_ctl_ff  <= ctl_new;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: finish pixels, write back, push results
   // ---------------------------------------------------------------------
   assign rd_word = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   lpcr_peak #(
      .PW (PW)
   ) u_peak (
      .ctl     (s1_ctl_ff),
      .px      (s1_px_ff),
      .a_self  (cur_ff[PW-1:0]),
      .a_up    (cur_ff[WW-1:PW]),
      .a_left  (last_va_ff),
      .a_right (rd_word[PW-1:0]),
      .b_self  (prev_px_ff),
      .b_up    (last_va_ff),
      .b_left  (tail_left_ff),
      .va      (va),
      .vb      (vb),
      .vc      (vc)
   );

   assign wr_word = {va, s1_px_ff};

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         // single column frame: the next pixel sees this write
         cur_ff     <= s1_wrap_ff ? wr_word : rd_word;
         prev_px_ff <= s1_px_ff;
         if (s1_ctl_ff.has_a) last_va_ff   <= va;
         if (s1_ctl_ff.has_b) tail_left_ff <= vb;
      end
   end

   // results in order: above, left on last row, frame end
   always_comb begin
      push_item[0].out_row  = s1_row_ff - ROW_W'(1);
      push_item[0].out_col  = OCW'(s1_col_ff);
      push_item[0].value    = VW'(va);
      push_item[0].run_last = !(s1_ctl_ff.has_b || s1_ctl_ff.has_c);
      push_item[1].out_row  = s1_row_ff;
      push_item[1].out_col  = OCW'(s1_col_ff - COL_W'(1));
      push_item[1].value    = VW'(vb);
      push_item[1].run_last = !s1_ctl_ff.has_c;
      push_item[2].out_row  = s1_row_ff;
      push_item[2].out_col  = OCW'(s1_col_ff);
      push_item[2].value    = VW'(vc);
      push_item[2].run_last = 1'b1;
      push_mask = {s1_ctl_ff.has_c, s1_ctl_ff.has_b, s1_ctl_ff.has_a} & {NR{s1_vld_ff}};
   end

   lpcr_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_mask (push_mask),
      .push_item (push_item),
      .pop       (rsp_valid && !rsp_stall),
      .head      (head),
      .level     (rsp_level)
   );

   assign rsp_valid    = rsp_level != '0;
   assign rsp_out_row  = head.out_row;
   assign rsp_out_col  = head.out_col;
   assign rsp_value    = head.value;
   assign rsp_run_last = head.run_last;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      int'(rsp_level) <= DEPTH)
      else $error("result queue over its depth");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (int'(rsp_level) + NR <= DEPTH))
      else $error("no room for the results of an accepted request");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (ECW'(s1_col_ff) < eff_cols_ff))
      else $error("column outside the frame");

   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> $past(s1_vld_ff))
      else $error("forward without a write in flight");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for local_peak_clip_raster_unit. Pixel requests and
// frame register writes are queued up front and played out by a clocked
// driver; an in-bench predictor tracks the line state and queues the clipped
// pixels, which the monitor compares field by field with every result.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpcr_pkg::*;

   localparam int LINE_LEN     = MAX_COLS_DEF;
   localparam int QUIET_CYCLES = 6;        // block is settled this long after a request
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 900000;
   localparam int REPORT_MAX   = 10;

   typedef enum logic [1:0] {OP_PIXEL, OP_WRITE} frame_op_kind_type;

   typedef struct {
      frame_op_kind_type      kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;    // pixel value or register data
   } frame_op_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ROW_W-1:0]       rsp_out_row;
   logic [OUT_COL_W-1:0]   rsp_out_col;
   logic [VALUE_W-1:0]     rsp_value;
   logic                   rsp_run_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   frame_op_type  frame_ops_q[$];
   rsp_item_type  clipped_q[$];
   int            mismatch_cnt = 0;
   int            cycle_cnt = 0;

   // predictor state
   logic [VALUE_W-1:0]    prior_fin [LINE_LEN];
   logic [PIXEL_W-1:0]    pend_orig [LINE_LEN];
   logic [VALUE_W-1:0]    left_fin = '0;
   logic [VALUE_W-1:0]    tail_fin = '0;
   int                    pos_row = 0;
   int                    pos_col = 0;
   logic [CFG_COLS_W-1:0] cfg_cols = 1;
   logic [CFG_ROWS_W-1:0] cfg_rows = 1;

   // driver / monitor pacing
   int gap_left = 0;
   int quiet_cnt = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int stall_left = 0;

   local_peak_clip_raster_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_value    (rsp_value),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // mostly no pause, else short pauses, a few long ones, and now and then a stretch of none
   function automatic int pause_len(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 150);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) $display("%s", msg);
   endtask

   // peak test: nbr/present ordered {right, down, left, up}
   function automatic logic [VALUE_W-1:0] peak_clip(input logic [VALUE_W-1:0] center,
                                                    input logic [3:0] present,
                                                    input logic [3:0][VALUE_W-1:0] nbr);
      logic               is_peak;
      logic [VALUE_W-1:0] top;
      is_peak = 1'b1;
      top = '0;
      for (int i = 0; i < 4; i++) begin
         if (present[i]) begin
            if (center <= nbr[i]) is_peak = 1'b0;
            else if (nbr[i] > top) top = nbr[i];
         end
      end
      return is_peak ? top : center;
   endfunction

   function automatic rsp_item_type make_rsp(input int row, input int col,
                                             input logic [VALUE_W-1:0] v);
      rsp_item_type item;
      item.out_row  = ROW_W'(row);
      item.out_col  = OUT_COL_W'(col);
      item.value    = v;
      item.run_last = 1'b0;
      return item;
   endfunction

   // register write as the block sees it; any known register restarts the frame
   task automatic apply_frame_cfg(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_FRAME_COLS) begin
         cfg_cols = data[CFG_COLS_W-1:0];
         pos_row = 0;
         pos_col = 0;
      end else if (idx == CSR_FRAME_ROWS) begin
         cfg_rows = data[CFG_ROWS_W-1:0];
         pos_row = 0;
         pos_col = 0;
      end
   endtask

   // one accepted pixel: finish what it releases and queue those results
   task automatic clip_next_pixel(input logic [PIXEL_W-1:0] px);
      int                 cols, rows, r, c, n;
      logic               last_row;
      logic [VALUE_W-1:0] v, right_orig;
      rsp_item_type       rel [3];
      cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);
      if (cols > LINE_LEN) cols = LINE_LEN;
      rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      r = pos_row;
      c = pos_col;
      if (c >= cols) c = 0;
      if (r >= rows) r = 0;
      last_row = (r + 1 >= rows);
      n = 0;

      // lower neighbor arrived: the pixel above is final
      if (r > 0) begin
         right_orig = '0;
         if (c + 1 < cols) right_orig = pend_orig[c + 1];
         v = peak_clip(pend_orig[c], {c + 1 < cols, 1'b1, c > 0, r > 1},
                       {right_orig, px, left_fin, prior_fin[c]});
         prior_fin[c] = v;
         left_fin = v;
         rel[n] = make_rsp(r - 1, c, v);
         n++;
      end

      // last row: right neighbor arrived for the pixel on the left
      if (last_row && c > 0) begin
         v = peak_clip(pend_orig[c - 1], {1'b1, 1'b0, c > 1, r > 0},
                       {px, 16'h0000, tail_fin, prior_fin[c - 1]});
         tail_fin = v;
         rel[n] = make_rsp(r, c - 1, v);
         n++;
      end

      pend_orig[c] = px;

      // last pixel of the frame is final on arrival
      if (last_row && c + 1 == cols) begin
         v = peak_clip(px, {2'b00, c > 0, r > 0},
                       {32'h0000_0000, tail_fin, prior_fin[c]});
         rel[n] = make_rsp(r, c, v);
         n++;
      end

      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      pos_col = c;
      pos_row = r;

      if (n > 0) rel[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++) clipped_q.push_back(rel[i]);
   endtask

   // request driver: pixels and register writes in queue order
   always @(posedge clock) begin : req_driver
      logic nxt_req, nxt_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         quiet_cnt = 0;
      end else begin
         nxt_req = req_valid;
         nxt_csr = csr_valid;
         if (req_valid && !req_stall) begin
            clip_next_pixel(req_pixel);
            frame_ops_q.delete(0);
            nxt_req = 1'b0;
            quiet_cnt = 0;
         end else if (quiet_cnt < QUIET_CYCLES) begin
            quiet_cnt++;
         end
         if (csr_valid && csr_ready) begin
            apply_frame_cfg(csr_index, csr_wdata);
            frame_ops_q.delete(0);
            nxt_csr = 1'b0;
         end
         if (!nxt_req && !nxt_csr && frame_ops_q.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (frame_ops_q[0].kind == OP_PIXEL) begin
               nxt_req = 1'b1;
               req_pixel <= frame_ops_q[0].data;
               gap_left = pause_len(req_calm);
            end else if (clipped_q.size() == 0 && quiet_cnt >= QUIET_CYCLES) begin
               // writes only go out once the block has drained
               nxt_csr = 1'b1;
               csr_index <= frame_ops_q[0].idx;
               csr_wdata <= frame_ops_q[0].data;
            end
         end
         req_valid <= nxt_req;
         csr_valid <= nxt_csr;
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      int           n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (clipped_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result: row=%0d col=%0d value=%0h last=%0b",
                                       rsp_out_row, rsp_out_col, rsp_value, rsp_run_last));
            end else begin
               want = clipped_q.pop_front();
               if (rsp_out_row !== want.out_row || rsp_out_col !== want.out_col ||
                   rsp_value !== want.value || rsp_run_last !== want.run_last)
                  note_mismatch($sformatf({"result mismatch: expected row=%0d col=%0d ",
                                           "value=%0h last=%0b, got row=%0d col=%0d ",
                                           "value=%0h last=%0b"},
                                          want.out_row, want.out_col, want.value,
                                          want.run_last, rsp_out_row, rsp_out_col,
                                          rsp_value, rsp_run_last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            n = pause_len(rsp_calm);
            stall_left = (n > 0) ? n - 1 : 0;
            rsp_stall <= (n > 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("local_peak_clip_raster_unit regression: fail");
         $finish;
      end
   end

   task automatic push_pixel(input logic [PIXEL_W-1:0] v);
      frame_ops_q.push_back('{kind: OP_PIXEL, idx: '0, data: v});
   endtask

   task automatic push_write(input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
      frame_ops_q.push_back('{kind: OP_WRITE, idx: idx, data: data});
   endtask

   // 0: tiny range for ties and peaks, 1: full range, else extremes mixed in
   function automatic logic [PIXEL_W-1:0] draw_pixel(input int style);
      case (style)
         0: return PIXEL_W'($urandom_range(0, 3));
         1: return PIXEL_W'($urandom);
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h0001;
               3: return 16'hFFFE;
               default: return PIXEL_W'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic push_run(input int count, input int style);
      for (int i = 0; i < count; i++) push_pixel(draw_pixel(style));
   endtask

   initial begin : stimulus
      int      rand_pixels, r, cols_w, rows_w, gen_cols, gen_rows, count, style;
      longint  area;

      // 1x1 frame straight out of reset: every pixel clips to zero
      push_pixel(16'hFFFF);
      push_pixel(16'h0000);
      // zero sizes read as one
      push_write(CSR_FRAME_ROWS, 16'h0000);
      push_write(CSR_FRAME_COLS, 16'h0000);
      push_pixel(16'h8000);

      // 3x3: center peak, corner peak, ties on the top edge
      push_write(CSR_FRAME_COLS, 16'd3);
      push_write(CSR_FRAME_ROWS, 16'd3);
      push_pixel(16'd7);   push_pixel(16'd7);    push_pixel(16'd2);
      push_pixel(16'd3);   push_pixel(16'd40);   push_pixel(16'd9);
      push_pixel(16'd5);   push_pixel(16'd9);    push_pixel(16'hFFFF);

      // write to an unused index mid-frame leaves the frame running
      push_write(CSR_FRAME_COLS, 16'd3);
      push_write(CSR_FRAME_ROWS, 16'd2);
      push_pixel(16'd1);   push_pixel(16'd6);    push_pixel(16'd1);
      push_write(CSR_IDX_W'((1 << CSR_IDX_W) - 1), 16'hFFFF);
      push_pixel(16'd4);   push_pixel(16'd2);    push_pixel(16'd8);

      // widest and tallest settings, then a restart mid-frame
      push_write(CSR_FRAME_COLS, 16'hFFFF);
      push_write(CSR_FRAME_ROWS, 16'hFFFF);
      push_run(4, 2);
      push_write(CSR_FRAME_COLS, 16'd2);
      push_run(4, 2);

      // single row frame, two pixels wide
      push_write(CSR_FRAME_ROWS, 16'd1);
      push_run(6, 1);
      gen_cols = 2;
      gen_rows = 1;

      // random frames: mostly small and complete, some cut short or restarted
      rand_pixels = 0;
      while (rand_pixels < 450) begin
         r = $urandom_range(0, 9);
         if (r < 6) cols_w = $urandom_range(1, 6);
         else if (r < 8) cols_w = $urandom_range(7, 24);
         else if (r == 8) cols_w = 0;
         else cols_w = $urandom_range(LINE_LEN + 1, (1 << CFG_COLS_W) - 1);
         r = $urandom_range(0, 9);
         if (r < 6) rows_w = $urandom_range(1, 5);
         else if (r < 8) rows_w = $urandom_range(6, 10);
         else if (r == 8) rows_w = 0;
         else rows_w = $urandom_range(11, (1 << CFG_ROWS_W) - 1);

         case ($urandom_range(0, 4))
            0: begin
               push_write(CSR_FRAME_ROWS, 16'(rows_w));
               push_write(CSR_FRAME_COLS, {5'($urandom), 11'(cols_w)});
            end
            1: push_write(CSR_FRAME_COLS, {5'($urandom), 11'(cols_w)});
            2: push_write(CSR_FRAME_ROWS, 16'(rows_w));
            default: begin
               push_write(CSR_FRAME_COLS, {5'($urandom), 11'(cols_w)});
               push_write(CSR_FRAME_ROWS, 16'(rows_w));
            end
         endcase
         if (frame_ops_q[$].idx == CSR_FRAME_COLS || frame_ops_q[$ - 1].idx == CSR_FRAME_COLS)
            gen_cols = (cols_w == 0) ? 1 : ((cols_w > LINE_LEN) ? LINE_LEN : cols_w);
         if (frame_ops_q[$].idx == CSR_FRAME_ROWS || frame_ops_q[$ - 1].idx == CSR_FRAME_ROWS)
            gen_rows = (rows_w == 0) ? 1 : rows_w;
         if ($urandom_range(0, 5) == 0)
            push_write(CSR_IDX_W'($urandom_range(CSR_FRAME_ROWS + 1, (1 << CSR_IDX_W) - 1)),
                       16'($urandom));

         area = longint'(gen_cols) * gen_rows;
         if (area <= 48) begin
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, int'(area));
            else count = int'(area) * $urandom_range(1, 3);
         end else begin
            count = $urandom_range(1, 40);
         end
         style = $urandom_range(0, 2);
         push_run(count, style);
         rand_pixels += count;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (frame_ops_q.size() != 0 || clipped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_cnt == 0 && clipped_q.size() == 0)
         $display("local_peak_clip_raster_unit regression: pass");
      else
         $display("local_peak_clip_raster_unit regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lpcr_pkg.sv
rtl/lpcr_ram.sv
rtl/lpcr_peak.sv
rtl/lpcr_rsp_fifo.sv
rtl/local_peak_clip_raster_unit.sv
sim/tb_top.sv
